// File: hw/rtl/star_topology_detector_macros.svh
// ---------------------------------------------------------------------------
// star topology detector assertion macros
// shared property wrappers for the detector's checks
// ---------------------------------------------------------------------------
`ifndef STAR_TOPOLOGY_DETECTOR_MACROS_SVH
`define STAR_TOPOLOGY_DETECTOR_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define STDET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define STDET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stdet_pkg.sv
// ---------------------------------------------------------------------------
// stdet_pkg
// types and fixed constants of the star topology detector
// ---------------------------------------------------------------------------
`default_nettype none

package stdet_pkg;

  // fixed field widths and scratch capacity
  localparam int ID_W     = 10;
  localparam int PTR_W    = 14;
  localparam int CFG_W    = 11;
  localparam int SCR_CAP  = 1023;

  // request function codes
  localparam logic [2:0] FN_OUT_PTR = 3'd0;
  localparam logic [2:0] FN_OUT_TGT = 3'd1;
  localparam logic [2:0] FN_IN_PTR  = 3'd2;
  localparam logic [2:0] FN_IN_SRC  = 3'd3;
  localparam logic [2:0] FN_QUERY   = 3'd4;

  // register indexes
  localparam logic REG_MIN_STAR = 1'b0;
  localparam logic REG_NODE_CNT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_STAR_RST = 11'd20;
  localparam logic [CFG_W-1:0] NODE_CNT_RST = 11'd1024;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_OS0, ST_OS1, ST_OS2, ST_OL, ST_OLD,
    ST_IS0, ST_IS1, ST_IS2, ST_IL, ST_ILD, ST_ILS,
    ST_LA, ST_LB, ST_LC, ST_LD, ST_LE, ST_LF, ST_LG, ST_LH, ST_LI, ST_LW,
    ST_DEC, ST_FLAG, ST_EA, ST_EB
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/star_topology_detector.sv
// ---------------------------------------------------------------------------
// star_topology_detector
// graph store with star query: lists neighbours, marks degree-one leaves and
// pages them out
// ---------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid/in_stall, func slot value page | request in
//  out      | out_valid/out_stall, seven result fields| result out
//  cfg      | psel penable pwrite paddr pwdata prdata | register port
//
//  loads are written straight into the tables while idle; a query lists the
//  out-entries, then the in-entries not yet seen, walks the in-entries of each
//  listed neighbour for its degree check, and scans the neighbours while paging out.
//  every step goes through synchronous table reads.
//  after reset a pass over all 1024 seen marks clears them before requests are taken.
//  a stalled result holds in the output register; the sequencer waits for it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "star_topology_detector_macros.svh"

module star_topology_detector
  import stdet_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_EDGES   = 8192,
  parameter int PAGE_LEAVES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [12:0] in_slot,
  input  wire logic [13:0] in_value,
  input  wire logic [9:0]  in_page_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_center,
  output logic             out_is_star,
  output logic [9:0]       out_leaf_count,
  output logic             out_leaf_valid,
  output logic [9:0]       out_leaf,
  output logic             out_more,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NIDX_W = $clog2(MAX_NODES + 1);
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int EP_W   = $clog2(MAX_EDGES + 1);

  // pointer saturation to the edge count
  function automatic logic [EP_W-1:0] sat_ptr(input logic [PTR_W-1:0] p);
    if (32'(p) > 32'(MAX_EDGES)) return EP_W'(MAX_EDGES);
    else return EP_W'(p);
  endfunction

  // configuration registers
  logic [CFG_W-1:0] min_star_r, node_cnt_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_NODE_CNT) ? 32'(node_cnt_r) : 32'(min_star_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_star_r <= MIN_STAR_RST;
      node_cnt_r <= NODE_CNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_STAR) min_star_r <= pwdata[CFG_W-1:0];
      else node_cnt_r <= pwdata[CFG_W-1:0];
    end
  end

  // sequencer state
  state_t          state_r, state_nxt;
  logic [NIDX_W-1:0] c_r, c_nxt;
  logic [9:0]      ps_r, ps_nxt, center_r, center_nxt;
  logic [EP_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt;
  logic [EP_W-1:0] olo_r, olo_nxt, ohi_r, ohi_nxt, ilo_r, ilo_nxt;
  logic [9:0]      n_r, n_nxt, j_r, j_nxt, cnt_r, cnt_nxt, v_r, v_nxt, t_r, t_nxt;
  logic [9:0]      clr_r, clr_nxt;
  logic [10:0]     idx_r, idx_nxt, end_r, end_nxt;
  logic            flag_r, flag_nxt, more_r, more_nxt, star_r, star_nxt;

  // memory ports
  logic [NIDX_W-1:0] os_ra, is_ra;
  logic [EIDX_W-1:0] ot_ra, isrc_ra;
  logic [PTR_W-1:0]  os_q, is_q;
  logic [ID_W-1:0]   ot_q, isrc_q;
  logic [ID_W:0]     scr_q;
  logic              seen_q;
  logic [9:0]        seen_ra;
  logic              scr_we, seen_we, seen_wd;
  logic [9:0]        scr_wa, seen_wa;
  logic [ID_W:0]     scr_wd;

  logic [PTR_W-1:0] os_mem   [MAX_NODES+1];
  logic [PTR_W-1:0] is_mem   [MAX_NODES+1];
  logic [ID_W-1:0]  ot_mem   [MAX_EDGES];
  logic [ID_W-1:0]  isrc_mem [MAX_EDGES];
  logic [ID_W:0]    scr_mem  [SCR_CAP+1];
  logic             seen_mem [SCR_CAP+1];

  // load requests while idle
  logic acc, ld_os, ld_is, ld_ot, ld_isrc;
  assign acc     = in_valid & ~in_stall;
  assign ld_os   = acc && in_func == FN_OUT_PTR && 32'(in_slot) <= 32'(MAX_NODES);
  assign ld_is   = acc && in_func == FN_IN_PTR  && 32'(in_slot) <= 32'(MAX_NODES);
  assign ld_ot   = acc && in_func == FN_OUT_TGT && 32'(in_slot) <  32'(MAX_EDGES);
  assign ld_isrc = acc && in_func == FN_IN_SRC  && 32'(in_slot) <  32'(MAX_EDGES);

  // graph tables
  always_ff @(posedge clk) begin
    if (ld_os) os_mem[NIDX_W'(in_slot)] <= in_value;
    os_q <= os_mem[os_ra];
  end
  always_ff @(posedge clk) begin
    if (ld_is) is_mem[NIDX_W'(in_slot)] <= in_value;
    is_q <= is_mem[is_ra];
  end
  always_ff @(posedge clk) begin
    if (ld_ot) ot_mem[EIDX_W'(in_slot)] <= in_value[ID_W-1:0];
    ot_q <= ot_mem[ot_ra];
  end
  always_ff @(posedge clk) begin
    if (ld_isrc) isrc_mem[EIDX_W'(in_slot)] <= in_value[ID_W-1:0];
    isrc_q <= isrc_mem[isrc_ra];
  end

  // neighbour scratch with leaf flag, and seen marks
  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    scr_q <= scr_mem[j_r];
  end
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    seen_q <= seen_mem[seen_ra];
  end

  // output register
  logic            emit, can_load;
  logic            o_star, o_lv, o_more, o_last;
  logic [9:0]      o_cnt, o_leaf;
  logic            out_valid_r;
  logic [9:0]      out_center_r, out_leaf_count_r, out_leaf_r;
  logic            out_is_star_r, out_leaf_valid_r, out_more_r, out_last_r;

  assign can_load = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      out_center_r     <= center_r;
      out_is_star_r    <= o_star;
      out_leaf_count_r <= o_cnt;
      out_leaf_valid_r <= o_lv;
      out_leaf_r       <= o_leaf;
      out_more_r       <= o_more;
      out_last_r       <= o_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center     = out_center_r;
  assign out_is_star    = out_is_star_r;
  assign out_leaf_count = out_leaf_count_r;
  assign out_leaf_valid = out_leaf_valid_r;
  assign out_leaf       = out_leaf_r;
  assign out_more       = out_more_r;
  assign out_last       = out_last_r;
  assign in_stall       = (state_r != ST_IDLE);

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end
  always_ff @(posedge clk) begin
    c_r <= c_nxt;  ps_r <= ps_nxt;  center_r <= center_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  i_r <= i_nxt;
    olo_r <= olo_nxt;  ohi_r <= ohi_nxt;  ilo_r <= ilo_nxt;
    n_r <= n_nxt;  j_r <= j_nxt;  cnt_r <= cnt_nxt;  v_r <= v_nxt;  t_r <= t_nxt;
    idx_r <= idx_nxt;  end_r <= end_nxt;
    flag_r <= flag_nxt;  more_r <= more_nxt;  star_r <= star_nxt;
  end

  // next state and memory control
  logic [EP_W-1:0]  os_sat, is_sat, ihi, ilen, olen;
  logic [CFG_W-1:0] nc;
  logic [10:0]      pend;

  assign os_sat = sat_ptr(os_q);
  assign is_sat = sat_ptr(is_q);
  assign ihi    = (is_sat < ilo_r) ? ilo_r : is_sat;
  assign ilen   = ihi - ilo_r;
  assign olen   = ohi_r - olo_r;
  assign nc     = (32'(node_cnt_r) > 32'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_cnt_r;
  assign pend   = 11'(ps_r) + 11'(PAGE_LEAVES);

  always_comb begin
    state_nxt = state_r;
    c_nxt = c_r;  ps_nxt = ps_r;  center_nxt = center_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;  i_nxt = i_r;
    olo_nxt = olo_r;  ohi_nxt = ohi_r;  ilo_nxt = ilo_r;
    n_nxt = n_r;  j_nxt = j_r;  cnt_nxt = cnt_r;  v_nxt = v_r;  t_nxt = t_r;
    clr_nxt = clr_r;  idx_nxt = idx_r;  end_nxt = end_r;
    flag_nxt = flag_r;  more_nxt = more_r;  star_nxt = star_r;
    os_ra = c_r;  is_ra = c_r;
    ot_ra = EIDX_W'(i_r);  isrc_ra = EIDX_W'(i_r);
    seen_ra = isrc_q;
    scr_we = 1'b0;  scr_wa = n_r;  scr_wd = {1'b0, ot_q};
    seen_we = 1'b0;  seen_wa = ot_q;  seen_wd = 1'b1;
    emit = 1'b0;  o_star = star_r;  o_cnt = cnt_r;  o_lv = 1'b0;  o_leaf = '0;
    o_more = 1'b0;  o_last = 1'b1;

    case (state_r)
      // seen marks cleared once after reset
      ST_CLEAR: begin
        seen_we = 1'b1;  seen_wa = clr_r;  seen_wd = 1'b0;
        clr_nxt = clr_r + 10'd1;
        if (clr_r == 10'(SCR_CAP)) state_nxt = ST_IDLE;
      end
      // take a request: loads write straight into the tables
      ST_IDLE: begin
        if (in_valid && in_func == FN_QUERY) begin
          center_nxt = in_slot[9:0];
          ps_nxt     = in_page_start;
          c_nxt      = NIDX_W'(in_slot);
          n_nxt      = '0;
          cnt_nxt    = '0;
          star_nxt   = 1'b0;
          if (32'(in_slot) >= 32'(nc)) state_nxt = ST_FLAG;
          else state_nxt = ST_OS0;
        end
      end
      // centre out-span
      ST_OS0: state_nxt = ST_OS1;
      ST_OS1: begin
        lo_nxt = os_sat;  os_ra = c_r + NIDX_W'(1);  state_nxt = ST_OS2;
      end
      ST_OS2: begin
        hi_nxt = (os_sat < lo_r) ? lo_r : os_sat;
        i_nxt = lo_r;  state_nxt = ST_OL;
      end
      // out-neighbours, each listed while the scratch has room
      ST_OL: begin
        if (i_r < hi_r && n_r != 10'(SCR_CAP)) state_nxt = ST_OLD;
        else state_nxt = ST_IS0;
      end
      ST_OLD: begin
        scr_we = 1'b1;  seen_we = 1'b1;
        n_nxt = n_r + 10'd1;  i_nxt = i_r + EP_W'(1);  state_nxt = ST_OL;
      end
      // centre in-span
      ST_IS0: state_nxt = ST_IS1;
      ST_IS1: begin
        lo_nxt = is_sat;  is_ra = c_r + NIDX_W'(1);  state_nxt = ST_IS2;
      end
      ST_IS2: begin
        hi_nxt = (is_sat < lo_r) ? lo_r : is_sat;
        i_nxt = lo_r;  state_nxt = ST_IL;
      end
      // in-neighbours not yet seen
      ST_IL: begin
        if (i_r < hi_r && n_r != 10'(SCR_CAP)) state_nxt = ST_ILD;
        else if (n_r == '0) state_nxt = ST_DEC;
        else begin
          j_nxt = '0;  state_nxt = ST_LA;
        end
      end
      ST_ILD: begin
        v_nxt = isrc_q;  state_nxt = ST_ILS;
      end
      ST_ILS: begin
        if (!seen_q) begin
          scr_we = 1'b1;  scr_wd = {1'b0, v_r};
          seen_we = 1'b1;  seen_wa = v_r;
          n_nxt = n_r + 10'd1;
        end
        i_nxt = i_r + EP_W'(1);  state_nxt = ST_IL;
      end
      // leaf check per listed neighbour; seen mark dropped on the way
      ST_LA: state_nxt = ST_LB;
      ST_LB: begin
        v_nxt = scr_q[ID_W-1:0];
        seen_we = 1'b1;  seen_wa = scr_q[ID_W-1:0];  seen_wd = 1'b0;
        if (32'(scr_q[ID_W-1:0]) >= 32'(MAX_NODES)) begin
          flag_nxt = 1'b0;  state_nxt = ST_LW;
        end else begin
          os_ra = NIDX_W'(scr_q[ID_W-1:0]);  state_nxt = ST_LC;
        end
      end
      ST_LC: begin
        olo_nxt = os_sat;  os_ra = NIDX_W'(v_r) + NIDX_W'(1);  state_nxt = ST_LD;
      end
      ST_LD: begin
        ohi_nxt = (os_sat < olo_r) ? olo_r : os_sat;
        is_ra = NIDX_W'(v_r);  state_nxt = ST_LE;
      end
      ST_LE: begin
        ilo_nxt = is_sat;  is_ra = NIDX_W'(v_r) + NIDX_W'(1);  state_nxt = ST_LF;
      end
      ST_LF: begin
        ot_ra = EIDX_W'(olo_r);
        hi_nxt = ihi;
        if (olen > EP_W'(1)) begin
          flag_nxt = 1'b0;  state_nxt = ST_LW;
        end else if (olen == '0) begin
          flag_nxt = (ilen == EP_W'(1));  state_nxt = ST_LW;
        end else state_nxt = ST_LG;
      end
      ST_LG: begin
        t_nxt = ot_q;  i_nxt = ilo_r;  state_nxt = ST_LH;
      end
      ST_LH: begin
        if (i_r < hi_r) state_nxt = ST_LI;
        else begin
          flag_nxt = 1'b1;  state_nxt = ST_LW;
        end
      end
      ST_LI: begin
        if (isrc_q != t_r) begin
          flag_nxt = 1'b0;  state_nxt = ST_LW;
        end else begin
          i_nxt = i_r + EP_W'(1);  state_nxt = ST_LH;
        end
      end
      ST_LW: begin
        scr_we = 1'b1;  scr_wa = j_r;  scr_wd = {flag_r, v_r};
        cnt_nxt = cnt_r + 10'(flag_r);
        j_nxt = j_r + 10'd1;
        if (j_r + 10'd1 == n_r) state_nxt = ST_DEC;
        else state_nxt = ST_LA;
      end
      // star decision and page bounds
      ST_DEC: begin
        j_nxt = '0;  idx_nxt = '0;
        more_nxt = (pend < 11'(cnt_r));
        end_nxt  = (pend < 11'(cnt_r)) ? pend : 11'(cnt_r);
        if (11'(cnt_r) < min_star_r) begin
          star_nxt = 1'b0;  state_nxt = ST_FLAG;
        end else if (ps_r >= cnt_r) begin
          star_nxt = 1'b1;  state_nxt = ST_FLAG;
        end else begin
          star_nxt = 1'b1;  state_nxt = ST_EA;
        end
      end
      // single flagged result
      ST_FLAG: begin
        if (can_load) begin
          emit = 1'b1;  state_nxt = ST_IDLE;
        end
      end
      // page out the leaves
      ST_EA: state_nxt = ST_EB;
      ST_EB: begin
        if (scr_q[ID_W] && idx_r >= 11'(ps_r)) begin
          if (can_load) begin
            emit = 1'b1;  o_lv = 1'b1;  o_leaf = scr_q[ID_W-1:0];
            o_more = more_r;  o_last = (idx_r + 11'd1 == end_r);
            idx_nxt = idx_r + 11'd1;  j_nxt = j_r + 10'd1;
            state_nxt = (idx_r + 11'd1 == end_r) ? ST_IDLE : ST_EA;
          end
        end else begin
          if (scr_q[ID_W]) idx_nxt = idx_r + 11'd1;
          j_nxt = j_r + 10'd1;  state_nxt = ST_EA;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // checks
  `STDET_ASSERT_IMPL(a_leaf_star, out_valid && out_leaf_valid, out_is_star, "leaf on non-star")
  `STDET_ASSERT_IMPL(a_flag_last, out_valid && !out_leaf_valid, out_last && !out_more, "flagged result not final")
  `STDET_ASSERT_IMPL(a_page_bound, state_r == ST_EB, idx_r < end_r, "page index past end")
  `STDET_ASSERT_NEXT(a_emit_valid, emit, out_valid, "result register not loaded")

endmodule

`default_nettype wire

// File: dv/star_topology_detector_checker.sv
// ---------------------------------------------------------------------------
// star topology detector checker
// watches the request, result and register ports, keeps its own copy of the
// graph tables and settings, and compares every result with its prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module star_topology_detector_checker
  import stdet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [12:0] in_slot,
  input  logic [13:0] in_value,
  input  logic [9:0]  in_page_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_center,
  input  logic        out_is_star,
  input  logic [9:0]  out_leaf_count,
  input  logic        out_leaf_valid,
  input  logic [9:0]  out_leaf,
  input  logic        out_more,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          queries,
  output int          results
);

  localparam int NODE_CAP = 1024;
  localparam int EDGE_CAP = 8192;
  localparam int PAGE     = 64;

  typedef struct packed {
    logic [ID_W-1:0] center;
    logic            is_star;
    logic [ID_W-1:0] leaf_count;
    logic            leaf_valid;
    logic [ID_W-1:0] leaf;
    logic            more;
    logic            last;
  } leaf_res_t;

  // local copy of the graph and settings
  logic [PTR_W-1:0] out_ptr_tab [0:NODE_CAP];
  logic [PTR_W-1:0] in_ptr_tab  [0:NODE_CAP];
  logic [ID_W-1:0]  out_tgt_mem [0:EDGE_CAP-1];
  logic [ID_W-1:0]  in_src_mem  [0:EDGE_CAP-1];
  logic [CFG_W-1:0] min_star;
  logic [CFG_W-1:0] node_lim;

  leaf_res_t star_pages_q [$];

  // pointer pair of one node, saturated and never reversed
  function automatic void span_of(input bit from_in, input int node,
                                  output int lo, output int hi);
    int a, b;
    a = from_in ? in_ptr_tab[node] : out_ptr_tab[node];
    b = from_in ? in_ptr_tab[node + 1] : out_ptr_tab[node + 1];
    if (a > EDGE_CAP) a = EDGE_CAP;
    if (b > EDGE_CAP) b = EDGE_CAP;
    if (b < a) b = a;
    lo = a;
    hi = b;
  endfunction

  // unique degree of exactly one
  function automatic bit leaf_node(input int v);
    int olo, ohi, ilo, ihi;
    logic [ID_W-1:0] tgt;
    span_of(1'b0, v, olo, ohi);
    span_of(1'b1, v, ilo, ihi);
    if (ohi - olo > 1) return 1'b0;
    if (ohi == olo) return (ihi - ilo) == 1;
    tgt = out_tgt_mem[olo];
    for (int i = ilo; i < ihi; i++)
      if (in_src_mem[i] != tgt) return 1'b0;
    return 1'b1;
  endfunction

  // neighbour listing, leaf count and one page of leaves
  function automatic void predict_star(input logic [12:0] slot, input logic [9:0] ps);
    int nc, sl, pstart, lo, hi, cnt, stop, idx;
    bit [NODE_CAP-1:0] seen;
    int nbr [$];
    logic [ID_W-1:0] v;
    leaf_res_t r;
    nc = (node_lim > NODE_CAP) ? NODE_CAP : node_lim;
    sl = slot;
    pstart = ps;
    r = '0;
    r.center = slot[ID_W-1:0];
    r.last = 1'b1;
    if (sl >= nc) begin
      star_pages_q.push_back(r);
      return;
    end
    seen = '0;
    span_of(1'b0, sl, lo, hi);
    for (int i = lo; i < hi && nbr.size() < SCR_CAP; i++) begin
      v = out_tgt_mem[i];
      nbr.push_back(v);
      seen[v] = 1'b1;
    end
    span_of(1'b1, sl, lo, hi);
    for (int i = lo; i < hi && nbr.size() < SCR_CAP; i++) begin
      v = in_src_mem[i];
      if (!seen[v]) begin
        nbr.push_back(v);
        seen[v] = 1'b1;
      end
    end
    cnt = 0;
    foreach (nbr[i])
      if (leaf_node(nbr[i])) cnt++;
    r.leaf_count = cnt[ID_W-1:0];
    if (cnt < min_star) begin
      star_pages_q.push_back(r);
      return;
    end
    r.is_star = 1'b1;
    if (pstart >= cnt) begin
      star_pages_q.push_back(r);
      return;
    end
    stop = (pstart + PAGE > cnt) ? cnt : pstart + PAGE;
    idx = 0;
    foreach (nbr[i]) begin
      if (idx >= stop) break;
      if (!leaf_node(nbr[i])) continue;
      if (idx >= pstart) begin
        r.leaf_valid = 1'b1;
        r.leaf = ID_W'(nbr[i]);
        r.more = (pstart + PAGE < cnt);
        r.last = (idx + 1 == stop);
        star_pages_q.push_back(r);
      end
      idx++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // sample all three ports at the clock edge
  always @(posedge clk) begin
    leaf_res_t want;
    if (!rst_n) begin
      errors = 0;
      queries = 0;
      results = 0;
      foreach (out_ptr_tab[i]) out_ptr_tab[i] = '0;
      foreach (in_ptr_tab[i]) in_ptr_tab[i] = '0;
      foreach (out_tgt_mem[i]) out_tgt_mem[i] = '0;
      foreach (in_src_mem[i]) in_src_mem[i] = '0;
      min_star = MIN_STAR_RST;
      node_lim = NODE_CNT_RST;
      star_pages_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MIN_STAR) min_star = pwdata[CFG_W-1:0];
        else node_lim = pwdata[CFG_W-1:0];
      end
      // accepted request
      if (in_valid && !in_stall) begin
        case (in_func)
          FN_OUT_PTR: if (in_slot <= NODE_CAP) out_ptr_tab[in_slot] = in_value;
          FN_IN_PTR:  if (in_slot <= NODE_CAP) in_ptr_tab[in_slot] = in_value;
          FN_OUT_TGT: out_tgt_mem[in_slot] = in_value[ID_W-1:0];
          FN_IN_SRC:  in_src_mem[in_slot] = in_value[ID_W-1:0];
          FN_QUERY: begin
            predict_star(in_slot, in_page_start);
            queries++;
          end
          default: ;
        endcase
      end
      // accepted result
      if (out_valid && !out_stall) begin
        results++;
        if (star_pages_q.size() == 0) begin
          $error("result with no request outstanding: center %0d", out_center);
          errors++;
        end else begin
          want = star_pages_q.pop_front();
          check_field("center", want.center, out_center);
          check_field("is_star", want.is_star, out_is_star);
          check_field("leaf_count", want.leaf_count, out_leaf_count);
          check_field("leaf_valid", want.leaf_valid, out_leaf_valid);
          check_field("leaf", want.leaf, out_leaf);
          check_field("more", want.more, out_more);
          check_field("last", want.last, out_last);
        end
      end
    end
    pending = star_pages_q.size();
  end

endmodule

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// star topology detector testbench
// loads small graphs, a hand-built one first and then random hub-and-spoke
// ones, under several settings, and ends with a long result hold-off;
// queries are checked by the checker while both sides idle at random
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stdet_pkg::*;

  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [12:0] in_slot;
  logic [13:0] in_value;
  logic [9:0]  in_page_start;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_center;
  logic        out_is_star;
  logic [9:0]  out_leaf_count;
  logic        out_leaf_valid;
  logic [9:0]  out_leaf;
  logic        out_more;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, queries, results;
  bit burst;
  bit hold_req;
  int node_setting;
  int e_src [$];
  int e_dst [$];

  star_topology_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_slot(in_slot),
    .in_value(in_value), .in_page_start(in_page_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_center(out_center),
    .out_is_star(out_is_star), .out_leaf_count(out_leaf_count),
    .out_leaf_valid(out_leaf_valid), .out_leaf(out_leaf), .out_more(out_more),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  star_topology_detector_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_slot(in_slot),
    .in_value(in_value), .in_page_start(in_page_start),
    .out_valid(out_valid), .out_stall(out_stall), .out_center(out_center),
    .out_is_star(out_is_star), .out_leaf_count(out_leaf_count),
    .out_leaf_valid(out_leaf_valid), .out_leaf(out_leaf), .out_more(out_more),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .errors(errors), .pending(pending), .queries(queries), .results(results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // one request; the gap before the next one is drawn after acceptance
  task automatic send_req(input logic [2:0] fn, input int slot, input int value,
                          input int ps);
    int gap;
    in_valid <= 1'b1;
    in_func <= fn;
    in_slot <= slot[12:0];
    in_value <= value[13:0];
    in_page_start <= ps[9:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(input logic idx, input int val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NODE_CNT) node_setting = val;
  endtask

  // pointer table and list of one direction, from the edge queues
  task automatic load_side(input bit inward, input int n, input bit bad_ptr);
    int lst [$];
    int starts [$];
    int val, k;
    for (int u = 0; u < n; u++) begin
      starts.push_back(lst.size());
      foreach (e_src[i])
        if ((inward ? e_dst[i] : e_src[i]) == u) lst.push_back(inward ? e_src[i] : e_dst[i]);
    end
    starts.push_back(lst.size());
    k = (n > 1) ? $urandom_range(1, n - 1) : 0;
    for (int u = 0; u <= n; u++) begin
      val = starts[u];
      // saturating first pointer and a pointer running backwards
      if (bad_ptr && u == 0) val = 8192 + $urandom_range(0, 8191);
      else if (bad_ptr && u == k) val = 0;
      send_req(inward ? FN_IN_PTR : FN_OUT_PTR, u, val, $urandom_range(0, 1023));
    end
    foreach (lst[i])
      send_req(inward ? FN_IN_SRC : FN_OUT_TGT, i, lst[i] + 1024 * $urandom_range(0, 15),
               $urandom_range(0, 1023));
  endtask

  // random hubs with spokes, some duplicates and stray edges
  task automatic make_graph(input int n);
    int hub [3];
    int hubs, h;
    e_src.delete();
    e_dst.delete();
    hubs = $urandom_range(1, 3);
    for (int i = 0; i < 3; i++) hub[i] = $urandom_range(0, n - 1);
    for (int v = 0; v < n; v++) begin
      h = hub[$urandom_range(0, hubs - 1)];
      if (v != h && $urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1)) begin
          e_src.push_back(h); e_dst.push_back(v);
        end else begin
          e_src.push_back(v); e_dst.push_back(h);
        end
        if ($urandom_range(0, 7) == 0) begin
          e_src.push_back(e_src[$]); e_dst.push_back(e_dst[$]);
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        e_src.push_back(v); e_dst.push_back($urandom_range(0, n - 1));
      end
    end
  endtask

  // queries mixed with ignored requests
  task automatic run_queries(input int n, input int count);
    int nc, pick, ps;
    nc = (node_setting > 1024) ? 1024 : node_setting;
    for (int q = 0; q < count; q++) begin
      pick = $urandom_range(0, 9);
      ps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
      if (pick == 0) begin
        if ($urandom_range(0, 1))
          send_req(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), $urandom_range(0, 8191),
                   $urandom_range(0, 16383), $urandom_range(0, 1023));
        else
          send_req($urandom_range(0, 1) ? FN_OUT_PTR : FN_IN_PTR, $urandom_range(1025, 8191),
                   $urandom_range(0, 16383), $urandom_range(0, 1023));
      end else if (pick == 1) begin
        send_req(FN_QUERY, $urandom_range(nc, 8191), 0, ps);
      end else begin
        send_req(FN_QUERY, $urandom_range(0, n - 1), $urandom_range(0, 16383), ps);
      end
    end
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end else begin
        w = burst ? 0 : $urandom_range(0, 4);
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #4000000;
    $display("star_topology_detector: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    int n;
    in_valid = 1'b0;
    in_func = FN_QUERY;
    in_slot = '0;
    in_value = '0;
    in_page_start = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst = 1'b0;
    hold_req = 1'b0;
    node_setting = NODE_CNT_RST;
    n = 5;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // hand-built graph: hub 0 with a duplicate target, a mutual edge and a back edge
    write_reg(REG_MIN_STAR, 1);
    write_reg(REG_NODE_CNT, 4);
    e_src = '{0, 0, 0, 1, 3};
    e_dst = '{1, 1, 2, 0, 0};
    load_side(1'b0, 4, 1'b0);
    load_side(1'b1, 4, 1'b0);
    send_req(FN_QUERY, 0, 0, 0);
    send_req(FN_QUERY, 0, 0, 1);
    send_req(FN_QUERY, 0, 0, 1023);
    send_req(FN_QUERY, 1, 0, 0);
    send_req(FN_QUERY, 2, 0, 0);
    send_req(FN_QUERY, 4, 0, 0);
    send_req(FN_QUERY, 8191, 0, 0);
    send_req(FN_SPARE_LO, 0, 16383, 1023);
    send_req(FN_SPARE_HI, 8191, 0, 0);
    send_req(FN_OUT_PTR, 1025, 0, 0);
    write_reg(REG_MIN_STAR, 0);
    send_req(FN_QUERY, 2, 0, 0);
    send_req(FN_QUERY, 3, 0, 0);
    write_reg(REG_MIN_STAR, 2047);
    send_req(FN_QUERY, 0, 0, 0);

    // random graphs under varying settings
    for (int p = 0; p < 3; p++) begin
      n = $urandom_range(5, 8);
      burst = (p == 1);
      case (p)
        0: write_reg(REG_NODE_CNT, n);
        1: write_reg(REG_NODE_CNT, 2047);
        default: write_reg(REG_NODE_CNT, $urandom_range(1, n));
      endcase
      write_reg(REG_MIN_STAR, (p == 2) ? $urandom_range(1, 4) : 1 + p);
      make_graph(n);
      load_side(1'b0, n, $urandom_range(0, 1));
      load_side(1'b1, n, $urandom_range(0, 1));
      run_queries(n, 8);
    end
    burst = 1'b0;

    // long hold-off on the result side while queries keep coming
    hold_req = 1'b1;
    run_queries(n, 6);

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d queries with %0d results over hand-built and random", queries,
             results);
    $display("graphs, bad pointers, threshold extremes and a long result hold-off");
    if (errors == 0) begin
      $display("star_topology_detector: match");
    end else begin
      $display("star_topology_detector: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/stdet_pkg.sv
hw/rtl/star_topology_detector.sv
dv/star_topology_detector_checker.sv
dv/tb_top.sv
